>>> rtl/srsw_pkg.sv
`timescale 1ns / 1ps
// srsw_pkg: shared constants, codes, types and helpers for the
// selective-repeat sender window. No dependencies.
package srsw_pkg;

    localparam int SEQ_COUNT = 20;
    localparam int SEQ_W     = $clog2(SEQ_COUNT);
    localparam int TMR_W     = 8;
    localparam int PKT_W     = 16;
    localparam int WIN_W     = 5;
    localparam int MODE_W    = 2;
    localparam int ACK_W     = 8;
    localparam int KIND_W    = 3;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int OUT_TDATA_W = ((SEQ_W + PKT_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NEW     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd5;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_TOTAL   = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_RST  = 5'd7;
    localparam logic [TMR_W-1:0] TIMEOUT_RST = 8'd16;
    localparam logic [PKT_W-1:0] TOTAL_RST   = 16'd0;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_SLIDE  = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    typedef logic [SEQ_W-1:0] seq_t;

    function automatic seq_t seq_inc(input seq_t s);
        seq_t r;
        if (s == seq_t'(SEQ_COUNT - 1))
            r = '0;
        else
            r = s + seq_t'(1);
        return r;
    endfunction

    // (to - from) mod SEQ_COUNT, both operands below SEQ_COUNT
    function automatic seq_t seq_dist(input seq_t from, input seq_t to);
        logic [SEQ_W:0] sum;
        logic [SEQ_W:0] r;
        sum = {1'b0, to} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, from};
        if (sum >= (SEQ_W+1)'(SEQ_COUNT))
            r = sum - (SEQ_W+1)'(SEQ_COUNT);
        else
            r = sum;
        return r[SEQ_W-1:0];
    endfunction

endpackage

>>> rtl/selective_repeat_sender_window.sv
`timescale 1ns / 1ps
// selective_repeat_sender_window: selective-repeat ARQ sender window with
// per-sequence ack flags and retransmit timers, scanned by one sequencer.
// Depends on srsw_pkg.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+------------------------------------
//  s_ (in)   | in  | s_tvalid / s_tready     | s_tuser = mode, s_tdata = ack_seq
//  m_ (out)  | out | m_tvalid / m_tready     | m_tuser = kind, m_tdata = seq, packet
//            |     |                         | index, m_tlast = last
//  apb cfg   | in  | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// Start, send, an ignored ack and an ack off the base pass through accept, then decode.
// An ack at the base walks the slide one entry a cycle up to the new base.
// A tick scans the outstanding entries one timer a cycle, except where an expiry waits on a stalled output.
// The output register frees the input side; a stalled m_tready holds the
// sequencer only where a further result must be written.
// rst_n clears the window, flags to one, timers to zero, registers to defaults.
module selective_repeat_sender_window
    import srsw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ACK_W-1:0]        s_tdata,   // [7:0] ack_seq
    input  logic [MODE_W-1:0]       s_tuser,   // [1:0] mode
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // [4:0] seq, [20:5] packet_index, rest zero
    output logic [KIND_W-1:0]       m_tuser,   // [2:0] kind
    output logic                    m_tlast,   // last
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    state_t                 state_reg, state_next;
    logic [WIN_W-1:0]       window_reg;
    logic [TMR_W-1:0]       timeout_reg;
    logic [PKT_W-1:0]       total_reg;

    logic                   flags_reg  [SEQ_COUNT];
    logic                   flags_next [SEQ_COUNT];
    logic [TMR_W-1:0]       timer_reg  [SEQ_COUNT];
    logic [TMR_W-1:0]       timer_next [SEQ_COUNT];
    seq_t                   base_reg, base_next;
    seq_t                   nseq_reg, nseq_next;
    logic [PKT_W-1:0]       npkt_reg, npkt_next;

    logic [MODE_W-1:0]      mode_reg;
    logic [ACK_W-1:0]       ack_reg;
    seq_t                   scan_reg, scan_next;
    seq_t                   rem_reg, rem_next;
    logic                   pend_valid_reg, pend_valid_next;
    seq_t                   pend_seq_reg, pend_seq_next;
    logic [PKT_W-1:0]       pend_pkt_reg, pend_pkt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      out_kind_reg, out_kind_next;
    seq_t                   out_seq_reg, out_seq_next;
    logic [PKT_W-1:0]       out_pkt_reg, out_pkt_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_load;

    logic                   out_free;
    logic                   in_acc;
    logic                   cfg_we;
    seq_t                   count;
    seq_t                   ack_s;
    logic                   ack_ok;
    logic                   grant;
    logic [TMR_W:0]         aged;
    logic                   expire;
    logic [PKT_W-1:0]       pkt_scan;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign cfg_we   = psel & penable & pwrite & pready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_TDATA_W'({out_pkt_reg, out_seq_reg});

    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW:  prdata = DATA_W'(window_reg);
            REG_TIMEOUT: prdata = DATA_W'(timeout_reg);
            REG_TOTAL:   prdata = DATA_W'(total_reg);
            default:     prdata = '0;
        endcase
    end

    assign count    = seq_dist(base_reg, nseq_reg);
    assign ack_s    = ack_reg[SEQ_W-1:0];
    assign ack_ok   = ({1'b0, ack_reg} < (ACK_W+1)'(SEQ_COUNT))
                      && (seq_dist(base_reg, ack_s) < count);
    assign grant    = ({1'b0, count} < (WIN_W+1)'(window_reg)) && flags_reg[nseq_reg]
                      && (npkt_reg < total_reg);
    assign aged     = {1'b0, timer_reg[scan_reg]} + (TMR_W+1)'(1);
    assign expire   = aged > {1'b0, timeout_reg};
    assign pkt_scan = npkt_reg - PKT_W'(rem_reg);

    always_comb
    begin
        state_next      = state_reg;
        flags_next      = flags_reg;
        timer_next      = timer_reg;
        base_next       = base_reg;
        nseq_next       = nseq_reg;
        npkt_next       = npkt_reg;
        scan_next       = scan_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_seq_next   = pend_seq_reg;
        pend_pkt_next   = pend_pkt_reg;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_pkt_next    = out_pkt_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (mode_reg)
                    MODE_START:
                    begin
                        if (out_free)
                        begin
                            for (int i = 0; i < SEQ_COUNT; i++)
                            begin
                                flags_next[i] = 1'b1;
                                timer_next[i] = '0;
                            end
                            base_next     = '0;
                            nseq_next     = '0;
                            npkt_next     = '0;
                            out_load      = 1'b1;
                            out_kind_next = KIND_IDLE;
                            out_seq_next  = '0;
                            out_pkt_next  = '0;
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    MODE_SEND:
                    begin
                        if (out_free)
                        begin
                            out_load      = 1'b1;
                            out_last_next = 1'b1;
                            if (grant)
                            begin
                                out_kind_next        = KIND_NEW;
                                out_seq_next         = nseq_reg;
                                out_pkt_next         = npkt_reg;
                                flags_next[nseq_reg] = 1'b0;
                                timer_next[nseq_reg] = TMR_W'(1);
                                nseq_next            = seq_inc(nseq_reg);
                                npkt_next            = npkt_reg + PKT_W'(1);
                            end
                            else
                            begin
                                out_kind_next = KIND_REFUSED;
                                out_seq_next  = '0;
                                out_pkt_next  = '0;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_ACK:
                    begin
                        if (out_free)
                        begin
                            if (!ack_ok)
                            begin
                                out_load      = 1'b1;
                                out_kind_next = KIND_IGNORED;
                                out_seq_next  = '0;
                                out_pkt_next  = '0;
                                out_last_next = 1'b1;
                                state_next    = ST_IDLE;
                            end
                            else
                            begin
                                flags_next[ack_s] = 1'b1;
                                timer_next[ack_s] = '0;
                                if (ack_s == base_reg)
                                begin
                                    scan_next  = seq_inc(base_reg);
                                    state_next = ST_SLIDE;
                                end
                                else
                                begin
                                    out_load      = 1'b1;
                                    out_kind_next = KIND_IDLE;
                                    out_seq_next  = '0;
                                    out_pkt_next  = '0;
                                    out_last_next = 1'b1;
                                    state_next    = ST_IDLE;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        scan_next       = base_reg;
                        rem_next        = count;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                endcase
            end
            ST_SLIDE:
            begin
                if (scan_reg != nseq_reg && flags_reg[scan_reg])
                    scan_next = seq_inc(scan_reg);
                else if (out_free)
                begin
                    base_next     = scan_reg;
                    out_load      = 1'b1;
                    out_kind_next = (scan_reg == nseq_reg && npkt_reg == total_reg)
                                    ? KIND_DONE : KIND_IDLE;
                    out_seq_next  = '0;
                    out_pkt_next  = '0;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (rem_reg == '0)
                    state_next = ST_FLUSH;
                else if (flags_reg[scan_reg])
                begin
                    scan_next = seq_inc(scan_reg);
                    rem_next  = rem_reg - seq_t'(1);
                end
                else if (!expire)
                begin
                    timer_next[scan_reg] = aged[TMR_W] ? '1 : aged[TMR_W-1:0];
                    scan_next            = seq_inc(scan_reg);
                    rem_next             = rem_reg - seq_t'(1);
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // earlier expiry goes out now, not last of the item
                    if (pend_valid_reg)
                    begin
                        out_load      = 1'b1;
                        out_kind_next = KIND_RESEND;
                        out_seq_next  = pend_seq_reg;
                        out_pkt_next  = pend_pkt_reg;
                        out_last_next = 1'b0;
                    end
                    pend_valid_next      = 1'b1;
                    pend_seq_next        = scan_reg;
                    pend_pkt_next        = pkt_scan;
                    timer_next[scan_reg] = TMR_W'(1);
                    scan_next            = seq_inc(scan_reg);
                    rem_next             = rem_reg - seq_t'(1);
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next = KIND_RESEND;
                        out_seq_next  = pend_seq_reg;
                        out_pkt_next  = pend_pkt_reg;
                    end
                    else
                    begin
                        out_kind_next = KIND_IDLE;
                        out_seq_next  = '0;
                        out_pkt_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= WINDOW_RST;
            timeout_reg    <= TIMEOUT_RST;
            total_reg      <= TOTAL_RST;
            for (int i = 0; i < SEQ_COUNT; i++)
            begin
                flags_reg[i] <= 1'b1;
                timer_reg[i] <= '0;
            end
            base_reg       <= '0;
            nseq_reg       <= '0;
            npkt_reg       <= '0;
            scan_reg       <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flags_reg      <= flags_next;
            timer_reg      <= timer_next;
            base_reg       <= base_next;
            nseq_reg       <= nseq_next;
            npkt_reg       <= npkt_next;
            scan_reg       <= scan_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (paddr[3:2])
                    REG_WINDOW:  window_reg  <= pwdata[WIN_W-1:0];
                    REG_TIMEOUT: timeout_reg <= pwdata[TMR_W-1:0];
                    REG_TOTAL:   total_reg   <= pwdata[PKT_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg <= s_tuser;
            ack_reg  <= s_tdata;
        end
        pend_seq_reg <= pend_seq_next;
        pend_pkt_reg <= pend_pkt_next;
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_pkt_reg  <= out_pkt_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> rtl/srsw_checker.sv
`timescale 1ns / 1ps
// srsw_checker: port-level assertions for selective_repeat_sender_window,
// bound to the top level. Depends on srsw_pkg.
module srsw_checker
    import srsw_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [OUT_TDATA_W-1:0]  m_tdata,
    input logic [KIND_W-1:0]       m_tuser,
    input logic                    m_tlast
);

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // only retransmissions can be non-final
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_RESEND |-> m_tlast)
        else $error("non-resend item without last");

    a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_RESEND && m_tuser != KIND_NEW |-> m_tdata == '0)
        else $error("seq/packet set on a status item");

    // while ready for input, any waiting result closes its item
    a_ready_means_closed: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tlast)
        else $error("ready for input with an item's results unfinished");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
